// ----- sv/sha_pkg.sv -----
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset  = 56;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned FifoDepth  = 4;

  typedef enum logic {
    OP_DATA   = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  // front -> back command
  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[idx];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[idx];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ----- sv/sha256_byte_stream_hasher_unit.sv -----
// channel  dir  tdata                      tuser            tlast
// s_axis   in   [7:0] message_byte         operation        -
// m_axis   out  [31:0] digest_word         word_index       last_word
// Bytes go in one per cycle while the back end is idle; every 64th byte starts
// the single shared round unit (64 rounds, one per cycle, plus fold). Finish
// pads one byte per cycle up to 64, compresses (twice if over 55 bytes were
// held), then shows 8 words. Reset returns the chaining words to their start
// values. A 4-entry queue lets input run ahead while the back end compresses.
module sha256_byte_stream_hasher_unit #(
  parameter int unsigned FifoDepth = sha_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);
  sha_pkg::cmd_t wcmd, rcmd;
  logic push, full, pop, empty;

  sha_front u_front (
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_user_i(s_axis_tuser),
    .push_o(push), .cmd_o(wcmd), .full_i(full)
  );

  sha_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(wcmd), .full_o(full),
    .pop_i(pop), .rdata_o(rcmd), .empty_o(empty)
  );

  sha_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cmd_i(rcmd), .pop_o(pop),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_o(m_axis_tdata), .m_user_o(m_axis_tuser), .m_last_o(m_axis_tlast)
  );
endmodule

// ----- sv/sha_fifo.sv -----
module sha_fifo #(
  parameter int unsigned Depth = sha_pkg::FifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sha_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output sha_pkg::cmd_t rdata_o,
  output logic          empty_o
);
  localparam int unsigned Aw = $clog2(Depth);

  sha_pkg::cmd_t        mem_q [Depth];
  logic [Aw-1:0]        wptr_q, rptr_q;
  logic [Aw:0]          cnt_q;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i && !full_o) wptr_q <= (wptr_q == Aw'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      if (pop_i && !empty_o) rptr_q <= (rptr_q == Aw'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push_i && !full_o) - (Aw+1)'(pop_i && !empty_o);
    end
  end
endmodule

// ----- sv/sha_front.sv -----
module sha_front (
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  logic [7:0]    s_data_i,
  input  logic          s_user_i,
  output logic          push_o,
  output sha_pkg::cmd_t cmd_o,
  input  logic          full_i
);
  // classify: tuser is operation
  assign s_ready_o   = !full_i;
  assign push_o      = s_valid_i && !full_i;
  assign cmd_o.finish = (s_user_i == sha_pkg::OP_FINISH);
  assign cmd_o.data  = s_data_i;
endmodule

// ----- sv/sha_back.sv -----
module sha_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  sha_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic [31:0]   m_data_o,
  output logic [2:0]    m_user_o,
  output logic          m_last_o
);
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ROUND = 6'b000010,
    ST_FOLD  = 6'b000100,
    ST_PAD   = 6'b001000,
    ST_LEN   = 6'b010000,
    ST_EMIT  = 6'b100000
  } st_e;

  st_e          st_q, st_d;
  logic [31:0]  w_q [16];      // message schedule window, w_q[0] is oldest
  logic [31:0]  h_q [8];
  logic [31:0]  r_q [8];
  logic [5:0]   fill_q;
  logic [63:0]  bits_q;
  logic [5:0]   rnd_q;
  logic         fin_q;         // compressing the final block
  logic [2:0]   oidx_q;
  logic [31:0]  obuf_q [8];
  logic [7:0]   pad_mark_q;    // 0x80 once per finish, zeros afterwards

  logic [31:0] wt, s0, s1, t1, t2, e1, e0, ch, mj, wnew;

  always_comb begin
    wt   = w_q[0];
    s0   = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    e1   = sha_pkg::rotr(r_q[4], 6) ^ sha_pkg::rotr(r_q[4], 11) ^ sha_pkg::rotr(r_q[4], 25);
    ch   = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
    t1   = r_q[7] + e1 + ch + sha_pkg::round_k(rnd_q) + wt;
    e0   = sha_pkg::rotr(r_q[0], 2) ^ sha_pkg::rotr(r_q[0], 13) ^ sha_pkg::rotr(r_q[0], 22);
    mj   = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
    t2   = e0 + mj;
  end

  assign pop_o     = (st_q == ST_IDLE) && !empty_i;
  assign m_valid_o = (st_q == ST_EMIT);
  assign m_data_o  = obuf_q[oidx_q];
  assign m_user_o  = oidx_q;
  assign m_last_o  = (oidx_q == 3'd7);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (!empty_i) begin
                  if (cmd_i.finish) st_d = ST_PAD;
                  else if (fill_q == 6'd63) st_d = ST_ROUND;
                end
      ST_ROUND: if (rnd_q == 6'd63) st_d = ST_FOLD;
      // padding spilled into a second block: keep zero filling
      ST_FOLD:  if (fin_q) st_d = ST_EMIT;
                else if (pad_mark_q == 8'h00) st_d = ST_PAD;
                else st_d = ST_IDLE;
      ST_PAD:   if (fill_q == 6'd63) st_d = ST_ROUND;
                else if (fill_q == 6'(sha_pkg::LenOffset - 1)) st_d = ST_LEN;
      ST_LEN:   if (fill_q == 6'd63) st_d = ST_ROUND;
      ST_EMIT:  if (m_ready_i && oidx_q == 3'd7) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  logic        wr_byte;
  logic [7:0]  byte_v;
  logic [7:0]  len_byte;

  always_comb begin
    len_byte = bits_q[8*(6'd63 - fill_q) +: 8];
    wr_byte = 1'b0;
    byte_v  = 8'h00;
    unique case (st_q)
      ST_IDLE: begin
        wr_byte = !empty_i && !cmd_i.finish;
        byte_v  = cmd_i.data;
      end
      ST_PAD: begin
        wr_byte = 1'b1;
        byte_v  = pad_mark_q;
      end
      ST_LEN: begin
        wr_byte = 1'b1;
        byte_v  = len_byte;
      end
      default: ;
    endcase
  end

  // byte shift into the window, big-endian within each word
  always_ff @(posedge clk_i) begin
    if (wr_byte) begin
      w_q[fill_q[5:2]] <= {w_q[fill_q[5:2]][23:0], byte_v};
    end else if (st_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      fill_q <= '0;
      bits_q <= '0;
      rnd_q  <= '0;
      fin_q  <= 1'b0;
      oidx_q <= '0;
      pad_mark_q <= 8'h80;
      for (int i = 0; i < 8; i++) begin
        h_q[i]    <= sha_pkg::init_h(3'(i));
        r_q[i]    <= '0;
        obuf_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (wr_byte) fill_q <= fill_q + 6'd1;
      if (st_q == ST_IDLE && !empty_i && !cmd_i.finish) bits_q <= bits_q + 64'd8;
      if (st_q == ST_PAD) pad_mark_q <= 8'h00;
      if (st_q == ST_LEN && fill_q == 6'd63) fin_q <= 1'b1;
      if (st_d == ST_ROUND && st_q != ST_ROUND) begin
        rnd_q <= '0;
        for (int i = 0; i < 8; i++) r_q[i] <= h_q[i];
      end else if (st_q == ST_ROUND) begin
        rnd_q <= rnd_q + 6'd1;
        r_q[7] <= r_q[6];
        r_q[6] <= r_q[5];
        r_q[5] <= r_q[4];
        r_q[4] <= r_q[3] + t1;
        r_q[3] <= r_q[2];
        r_q[2] <= r_q[1];
        r_q[1] <= r_q[0];
        r_q[0] <= t1 + t2;
      end
      if (st_q == ST_FOLD) begin
        if (fin_q) begin
          for (int i = 0; i < 8; i++) begin
            obuf_q[i] <= h_q[i] + r_q[i];
            h_q[i]    <= sha_pkg::init_h(3'(i));
          end
          fin_q      <= 1'b0;
          bits_q     <= '0;
          pad_mark_q <= 8'h80;
          oidx_q     <= '0;
        end else begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
        end
      end
      if (st_q == ST_EMIT && m_ready_i) oidx_q <= oidx_q + 3'd1;
    end
  end
endmodule

// ----- sv/sha_checker.sv -----
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
    else $error("tlast mismatch");
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
    else $error("word sequence broken");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tuser)))
    else $error("stalled word changed");
endmodule

bind sha256_byte_stream_hasher_unit sha_checker u_sha_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tlast
);
